// ----- rtl/core/ptcu_pkg.sv -----
// Shared types, constants and helpers for the PWM timer compare unit.
package ptcu_pkg;

  localparam int DEF_NUM_CHANNELS = 5;
  localparam int DEF_TIMER_WIDTH  = 16;

  localparam int PERIOD_W    = 16;
  localparam int DUTY_W      = 16;
  localparam int CHAN_W      = 3;
  localparam int CODE_W      = 3;
  localparam int PRESCALE_W  = 8;
  localparam int LINES_W     = 5;
  localparam int COUNT_OUT_W = 16;

  localparam int IN_DATA_W  = 24;  // channel(3) + duty(16), padded to bytes
  localparam int OUT_DATA_W = 24;  // lines(5) + count(16) + wrap + ok, padded
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE   = 2'd2;

  // Word kinds carried on in_tuser
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_DUTY = 1'b1;

  localparam logic [CODE_W-1:0] PRESCALE_CODE_MAX = 3'd7;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'hFFFF;

  // Terminal count of the prescaler: 2^code - 1, code 7 gives 255.
  function automatic logic [PRESCALE_W-1:0] prescale_limit(input logic [CODE_W-1:0] code);
    logic [PRESCALE_W-1:0] lim;
    unique case (code)
      PRESCALE_CODE_MAX: lim = '1;
      default:           lim = (PRESCALE_W'(1) << code) - PRESCALE_W'(1);
    endcase
    return lim;
  endfunction

endpackage

// ----- rtl/core/pwm_timer_compare_unit.sv -----
// Top level: PWM timer compare unit with stream in/out and config write port.
// A result word shows on out_tdata in the cycle after its input word is taken.
// Throughput: one word per cycle; a single output register, refilled whenever
//   it drains, so in_tready stays high unless a held result is stalled.
// Reset (rst_n, synchronous, active low): period 0xFFFF, prescale code 0,
//   timer disabled, prescaler/timer zero, all channels off, output empty.
module pwm_timer_compare_unit
  import ptcu_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int TIMER_WIDTH  = DEF_TIMER_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [2:0] channel, [18:3] duty_value, rest 0
  input  logic                  in_tuser,   // [0] req_type (0 tick, 1 duty write)
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] pwm_lines, [20:5] timer_count,
                                            // [21] period_wrap, [22] write_ok, [23] 0
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic [PERIOD_W-1:0] period_r;
  logic [CODE_W-1:0]   code_r;
  logic                enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      code_r   <= '0;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PERIOD:   period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_PRESCALE: code_r   <= cfg_wdata[CODE_W-1:0];
        REG_ENABLE:   enable_r <= cfg_wdata[0];
        default:      ;  // unmapped index, ignored
      endcase
    end
  end

  // ---------------- input side ----------------
  logic                  in_acc;
  logic [CHAN_W-1:0]     in_chan;
  logic [DUTY_W-1:0]     in_duty;
  logic                  tick_step;
  logic                  duty_wr;

  assign in_acc    = in_tvalid && in_tready;
  assign in_chan   = in_tdata[CHAN_W-1:0];
  assign in_duty   = in_tdata[CHAN_W +: DUTY_W];
  assign tick_step = in_acc && (in_tuser == REQ_TICK) && enable_r;
  assign duty_wr   = in_acc && (in_tuser == REQ_DUTY);

  // ---------------- datapath ----------------
  logic [TIMER_WIDTH-1:0]  count_nxt;
  logic                    wrap_nxt;
  logic                    wr_ok;
  logic [NUM_CHANNELS-1:0] lines_nxt;
  logic [LINES_W-1:0]      lines_out;

  ptcu_timebase #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_timebase (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (tick_step),
    .period    (period_r),
    .code      (code_r),
    .count_nxt (count_nxt),
    .wrap_nxt  (wrap_nxt)
  );

  ptcu_compare #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TIMER_WIDTH  (TIMER_WIDTH)
  ) u_compare (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (duty_wr),
    .wr_chan   (in_chan),
    .wr_duty   (in_duty),
    .count_nxt (count_nxt),
    .wr_ok     (wr_ok),
    .lines_nxt (lines_nxt)
  );

  // only the low five lines are reported; fewer channels pad with zeros
  if (NUM_CHANNELS >= LINES_W) begin : g_lines_cut
    assign lines_out = lines_nxt[LINES_W-1:0];
  end else begin : g_lines_pad
    assign lines_out = LINES_W'(lines_nxt);
  end

  // count reported as its low 16 bits, zero-extended for narrow timers
  localparam int CNT_EXT_W = (TIMER_WIDTH > COUNT_OUT_W) ? TIMER_WIDTH : COUNT_OUT_W;
  logic [CNT_EXT_W-1:0] count_ext;
  assign count_ext = CNT_EXT_W'(count_nxt);

  // ---------------- output register / skid ----------------
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {1'b0, wr_ok, wrap_nxt, count_ext[COUNT_OUT_W-1:0], lines_out};
    end
  end

endmodule

// ----- rtl/core/ptcu_timebase.sv -----
// Prescaler and shared up-counting timer with period wrap.
module ptcu_timebase
  import ptcu_pkg::*;
#(
  parameter int TIMER_WIDTH = DEF_TIMER_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,        // accepted tick with timer enabled
  input  logic [PERIOD_W-1:0]    period,
  input  logic [CODE_W-1:0]      code,
  output logic [TIMER_WIDTH-1:0] count_nxt,
  output logic                   wrap_nxt
);

  localparam int CMP_W = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;

  logic [PRESCALE_W-1:0]  presc_r, presc_nxt;
  logic [TIMER_WIDTH-1:0] count_r;
  logic [CMP_W-1:0]       count_ext, period_ext;
  logic                   div_done;

  assign count_ext  = CMP_W'(count_r);
  // period is masked to the timer width before the compare
  assign period_ext = CMP_W'(TIMER_WIDTH'(period));
  assign div_done   = presc_r >= prescale_limit(code);

  always_comb begin
    presc_nxt = presc_r;
    count_nxt = count_r;
    wrap_nxt  = 1'b0;
    if (step) begin
      if (div_done) begin
        presc_nxt = '0;
        if (count_ext >= period_ext) begin
          count_nxt = '0;
          wrap_nxt  = 1'b1;
        end else begin
          count_nxt = count_r + TIMER_WIDTH'(1);
        end
      end else begin
        presc_nxt = presc_r + PRESCALE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r <= '0;
      count_r <= '0;
    end else begin
      presc_r <= presc_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- rtl/core/ptcu_compare.sv -----
// Compare channel bank: duty registers, enables and line levels.
module ptcu_compare
  import ptcu_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int TIMER_WIDTH  = DEF_TIMER_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,      // accepted duty write
  input  logic [CHAN_W-1:0]       wr_chan,
  input  logic [DUTY_W-1:0]       wr_duty,
  input  logic [TIMER_WIDTH-1:0]  count_nxt,
  output logic                    wr_ok,
  output logic [NUM_CHANNELS-1:0] lines_nxt
);

  localparam int CMP_W = (TIMER_WIDTH > DUTY_W) ? TIMER_WIDTH : DUTY_W;

  logic [DUTY_W-1:0]       duty_r   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] active_r;

  assign wr_ok = wr_en && ({1'b0, wr_chan} < (CHAN_W+1)'(NUM_CHANNELS));

  for (genvar n = 0; n < NUM_CHANNELS; n++) begin : g_ch
    logic             hit;
    logic [DUTY_W-1:0] duty_nxt;
    logic             active_nxt;

    assign hit        = wr_en && (wr_chan == CHAN_W'(n));
    assign duty_nxt   = hit ? wr_duty : duty_r[n];
    assign active_nxt = hit | active_r[n];
    // new duty applies to this very word's result
    assign lines_nxt[n] = active_nxt && (CMP_W'(count_nxt) < CMP_W'(duty_nxt));

    always_ff @(posedge clk) begin
      if (hit) begin
        duty_r[n] <= wr_duty;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        active_r[n] <= 1'b0;
      end else begin
        active_r[n] <= active_nxt;
      end
    end
  end

endmodule

// ----- tb/tb_pwm_timer_compare_unit.sv -----
// Self-checking testbench for the PWM timer compare unit: directed table, then random phases.
`timescale 1ns / 1ps

module tb_pwm_timer_compare_unit
  import ptcu_pkg::*;
;

  localparam int ITEMS_PER_PHASE = 172;
  localparam int NUM_PHASES      = 8;
  localparam int HOLD_CYCLES     = 64;   // long back-pressure stretch on the result side
  localparam int DRAIN_CYCLES    = 4;    // margin after the final drain, for stray result words

  // Result word as it sits in out_tdata[22:0]; first member is the top bit.
  typedef struct packed {
    logic                   ok;
    logic                   wrap;
    logic [COUNT_OUT_W-1:0] count;
    logic [LINES_W-1:0]     lines;
  } pwm_result_t;

  // Directed table row: either one input word or one register write.
  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             op;
    logic                  req;      // REQ_TICK / REQ_DUTY
    logic [CHAN_W-1:0]     chan;
    logic [DUTY_W-1:0]     value;    // duty for a word, data for a register write
    logic [CFG_ADDR_W-1:0] reg_idx;
    bit                    typed;    // result below is written out by hand
    pwm_result_t           res;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pwm_timer_compare_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow copy of the block's registers and counters
  // ---------------------------------------------------------------------------
  logic [PERIOD_W-1:0]    cur_period;
  logic [CODE_W-1:0]      cur_code;
  logic                   cur_enable;
  logic [PRESCALE_W-1:0]  tick_div_count;
  logic [COUNT_OUT_W-1:0] timer_now;
  logic [DUTY_W-1:0]      duty_of [DEF_NUM_CHANNELS];
  logic                   chan_on [DEF_NUM_CHANNELS];

  pwm_result_t pending_results [$];   // expected result words, oldest first
  dir_row_t    directed_rows [$];

  int  mismatches   = 0;
  int  n_ticks      = 0;
  int  n_duty       = 0;
  int  n_refused    = 0;
  int  n_wraps_seen = 0;
  int  n_reg_writes = 0;
  bit  quiet_link   = 0;   // both sides run without gaps while set
  bit  hold_request = 0;   // asks the result side for one long stall

  // Advance the shadow state by one accepted word and return its result.
  function automatic pwm_result_t apply_word(input logic req, input logic [CHAN_W-1:0] chan,
                                             input logic [DUTY_W-1:0] duty);
    pwm_result_t           r;
    logic [PRESCALE_W-1:0] div_last;
    bit                    step_timer;
    r = '0;
    step_timer = 0;
    if (req == REQ_TICK) begin
      if (cur_enable) begin
        // divider terminal count: 2^code - 1, top code saturates at 255
        div_last = (cur_code == PRESCALE_CODE_MAX) ? 8'hFF
                                                   : 8'(8'hFF >> (4'd8 - {1'b0, cur_code}));
        if (tick_div_count >= div_last) begin
          tick_div_count = '0;
          step_timer = 1;
        end else begin
          tick_div_count = tick_div_count + 1'b1;
        end
        if (step_timer) begin
          // >= so a period lowered under the count wraps on the next step
          if (timer_now >= cur_period) begin
            timer_now = '0;
            r.wrap = 1'b1;
          end else begin
            timer_now = timer_now + 1'b1;
          end
        end
      end
    end else if (chan < DEF_NUM_CHANNELS) begin
      duty_of[chan] = duty;
      chan_on[chan] = 1'b1;
      r.ok = 1'b1;
    end
    for (int n = 0; n < DEF_NUM_CHANNELS; n++)
      r.lines[n] = chan_on[n] && (timer_now < duty_of[n]);
    r.count = timer_now;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and time limit
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : run_limit
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic req, input logic [CHAN_W-1:0] chan,
                           input logic [DUTY_W-1:0] duty, input bit typed,
                           input pwm_result_t typed_res);
    int          gap;
    pwm_result_t predicted;
    gap = quiet_link ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {5'b0, duty, chan};
    do @(posedge clk); while (!in_tready);
    // word taken at this edge: shadow state moves now, result follows later
    predicted = apply_word(req, chan, duty);
    pending_results.push_back(typed ? typed_res : predicted);
    if (req == REQ_TICK) n_ticks++;
    else if (predicted.ok) n_duty++;
    else n_refused++;
    @(negedge clk);
  endtask

  // Stop offering words and wait until every expected result has come back.
  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    case (idx)
      REG_PERIOD:   cur_period = val;
      REG_PRESCALE: cur_code   = val[CODE_W-1:0];
      REG_ENABLE:   cur_enable = val[0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold on request, field-by-field check
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int          stall;
    pwm_result_t got;
    pwm_result_t want;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        // long stall so the output register fills and in_tready drops
        hold_request = 0;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = quiet_link ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[22:0];
      if (got.wrap) n_wraps_seen++;
      if (pending_results.size() == 0) begin
        $error("result word %h arrived with nothing expected", out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.lines !== want.lines) begin
          $error("pwm_lines: expected %h, got %h", want.lines, got.lines);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("timer_count: expected %h, got %h", want.count, got.count);
          mismatches++;
        end
        if (got.wrap !== want.wrap) begin
          $error("period_wrap: expected %b, got %b", want.wrap, got.wrap);
          mismatches++;
        end
        if (got.ok !== want.ok) begin
          $error("write_ok: expected %b, got %b", want.ok, got.ok);
          mismatches++;
        end
      end
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [PERIOD_W-1:0] new_period;
    logic [CODE_W-1:0]   new_code;
    logic                new_enable;
    logic                req;
    logic [CHAN_W-1:0]   chan;
    logic [DUTY_W-1:0]   duty;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = REQ_TICK;
    cfg_we    = 1'b0;
    cfg_addr  = REG_PERIOD;
    cfg_wdata = '0;

    // shadow state after reset
    cur_period     = PERIOD_RESET;
    cur_code       = '0;
    cur_enable     = 1'b0;
    tick_div_count = '0;
    timer_now      = '0;
    for (int n = 0; n < DEF_NUM_CHANNELS; n++) begin
      duty_of[n] = '0;
      chan_on[n] = 1'b0;
    end

    // Directed table. Hand-written results are {ok, wrap, count, lines}.
    // tick while the timer is off: nothing moves
    directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b1,
                              {1'b0, 1'b0, 16'h0000, 5'h00}});
    // writes to nonexistent channels are refused
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd7, 16'hFFFF, REG_PERIOD, 1'b1,
                              {1'b0, 1'b0, 16'h0000, 5'h00}});
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd5, 16'h0001, REG_PERIOD, 1'b1,
                              {1'b0, 1'b0, 16'h0000, 5'h00}});
    // duty writes land even with the timer off; full duty high, zero duty low
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd0, 16'hFFFF, REG_PERIOD, 1'b1,
                              {1'b1, 1'b0, 16'h0000, 5'h01}});
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd1, 16'h0000, REG_PERIOD, 1'b1,
                              {1'b1, 1'b0, 16'h0000, 5'h01}});
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd4, 16'h0003, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd2, 16'h0001, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd3, 16'h8000, REG_PERIOD, 1'b0, '0});
    // short period, run the timer up to 5
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd6, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd1, REG_ENABLE, 1'b0, '0});
    repeat (5)
      directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b0, '0});
    // period dropped below the count: next step wraps
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd1, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b0, '0});
    // duty above the period stays high; new duty acts at once
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd2, 16'h0005, REG_PERIOD, 1'b0, '0});
    // divide by 8, stop part way, then shrink the divider under its count
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd3, REG_PRESCALE, 1'b0, '0});
    repeat (5)
      directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd1, REG_PRESCALE, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b0, '0});
    // zero period at the top divide code
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd7, REG_PRESCALE, 1'b0, '0});
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd0, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_DUTY, 3'd6, 16'hAAAA, REG_PERIOD, 1'b0, '0});
    directed_rows.push_back('{ROW_REG, REQ_TICK, 3'd0, 16'd0, REG_ENABLE, 1'b0, '0});
    directed_rows.push_back('{ROW_WORD, REQ_TICK, 3'd0, 16'h0000, REG_PERIOD, 1'b0, '0});

    // hold synchronous reset, then release it on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_REG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_word(directed_rows[i].req, directed_rows[i].chan, directed_rows[i].value,
                  directed_rows[i].typed, directed_rows[i].res);
      end
    end

    // Random phases, each with its own register setting.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin  // wrap on every timer step
          new_period = '0;
          new_code   = '0;
          new_enable = 1'b1;
        end
        1: begin  // slowest setting
          new_period = 16'hFFFF;
          new_code   = PRESCALE_CODE_MAX;
          new_enable = 1'b1;
        end
        2: begin  // back-pressure phase
          new_period = 16'($urandom_range(1, 40));
          new_code   = '0;
          new_enable = 1'b1;
        end
        3: begin  // timer off, writes only matter
          new_period = 16'($urandom);
          new_code   = 3'($urandom_range(0, 7));
          new_enable = 1'b0;
        end
        default: begin
          new_period = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 60));
          new_code   = ($urandom_range(0, 3) == 0) ? PRESCALE_CODE_MAX
                                                   : 3'($urandom_range(0, 3));
          new_enable = ($urandom_range(0, 7) != 0);
        end
      endcase
      write_reg(REG_PERIOD, new_period);
      write_reg(REG_PRESCALE, {13'b0, new_code});
      write_reg(REG_ENABLE, {15'b0, new_enable});

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (phase == 2 && k == 0) begin
          // keep offering words back to back while the result side stalls
          quiet_link   = 1;
          hold_request = 1;
        end else if (phase == 2 && k == 100) begin
          // pause the sender until everything in flight has come out
          drain_results();
          quiet_link = 0;
        end else if (phase != 2 && k % 32 == 0) begin
          quiet_link = ($urandom_range(0, 3) == 0);
        end

        req  = ($urandom_range(0, 3) == 0) ? REQ_DUTY : REQ_TICK;
        chan = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 5))
          0:       duty = '0;
          1:       duty = cur_period;
          2:       duty = cur_period + 1'b1;
          3:       duty = 16'hFFFF;
          4:       duty = 16'($urandom_range(0, 32'(cur_period) + 2));
          default: duty = 16'($urandom);
        endcase
        send_word(req, chan, duty, 1'b0, '0);
      end
    end

    // all words taken: wait for the tail, then a margin for strays
    quiet_link = 0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks, %0d accepted and %0d refused duty writes, %0d wraps,",
             n_ticks, n_duty, n_refused, n_wraps_seen);
    $display("  %0d register writes over %0d random phases, with a long output stall.",
             n_reg_writes, NUM_PHASES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ptcu_pkg.sv
rtl/core/ptcu_timebase.sv
rtl/core/ptcu_compare.sv
rtl/core/pwm_timer_compare_unit.sv
tb/tb_pwm_timer_compare_unit.sv
